// File: rtl/u8u16_pkg.sv
// Shared types, status codes and helpers for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  // Status codes carried in the final report of a buffer.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CONT  = 3'd2;
  localparam logic [2:0] ST_OVERLONG  = 3'd3;
  localparam logic [2:0] ST_SURROGATE = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  // Kinds of result item.
  localparam logic KIND_UNIT   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // One input byte can cause at most a surrogate pair and a report.
  localparam int unsigned MAX_RESULTS = 3;

  // Depth of the result queue and the width of its pointers.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  // Result item.
  typedef struct packed {
    logic        item_kind;
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic [15:0] consumed_bytes;
    logic [15:0] produced_units;
    logic        last_of_run;
  } out_t;

  // Per-buffer decoder state, apart from the counters.
  typedef struct packed {
    logic [1:0]  need;
    logic [2:0]  len;
    logic [20:0] cp;
    logic        stopped;
    logic [2:0]  held;
  } state_t;

  // A result item that carries one UTF-16 code unit.
  function automatic out_t make_unit(logic [15:0] unit);
    out_t r;
    r           = '0;
    r.item_kind = KIND_UNIT;
    r.code_unit = unit;
    return r;
  endfunction

endpackage

// File: rtl/u8u16_decode.sv
// Per-byte decode: next decoder state, counters and the result items of one byte.
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  state_t                          state_i,
  input  logic [COUNT_BITS-1:0]           consumed_i,
  input  logic [COUNT_BITS-1:0]           produced_i,
  input  logic [15:0]                     capacity_i,
  input  in_t                             req_i,
  output state_t                          state_o,
  output logic [COUNT_BITS-1:0]           consumed_o,
  output logic [COUNT_BITS-1:0]           produced_o,
  output out_t [MAX_RESULTS-1:0]          res_o,
  output logic [1:0]                      res_num_o
);

  // Compare width wide enough for both the counter and the capacity, plus a carry.
  localparam int unsigned WW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  state_t                st;
  logic [COUNT_BITS-1:0] cons;
  logic [COUNT_BITS-1:0] prod;
  logic [COUNT_BITS:0]   csum;
  logic [COUNT_BITS:0]   psum;
  logic                  finish;
  logic [1:0]            units;
  logic [20:0]           vfull;
  logic [WW-1:0]         demand;
  logic [WW-1:0]         cons_w;
  logic [WW-1:0]         prod_w;
  out_t [MAX_RESULTS-1:0] res;
  logic [1:0]            n;
  logic [7:0]            b;

  // Stop conversion with the given status.
  function automatic state_t halt(state_t s, logic [2:0] code);
    state_t r;
    r         = s;
    r.stopped = 1'b1;
    r.held    = code;
    r.need    = 2'd0;
    return r;
  endfunction

  always_comb begin
    st     = state_i;
    cons   = consumed_i;
    prod   = produced_i;
    finish = 1'b0;
    units  = 2'd1;
    vfull  = '0;
    demand = '0;
    csum   = '0;
    psum   = '0;
    cons_w = '0;
    prod_w = '0;
    res    = '0;
    n      = 2'd0;
    b      = req_i.in_byte;

    // Lead and continuation byte handling.
    if (!st.stopped) begin
      if (st.need == 2'd0) begin
        if (!b[7]) begin
          st.cp  = {13'd0, b};
          st.len = 3'd1;
          finish = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          st.cp   = {16'd0, b[4:0]};
          st.len  = 3'd2;
          st.need = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          st.cp   = {17'd0, b[3:0]};
          st.len  = 3'd3;
          st.need = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          st.cp   = {18'd0, b[2:0]};
          st.len  = 3'd4;
          st.need = 2'd3;
        end else begin
          st = halt(st, ST_BAD_LEAD);
        end
      end else if (b[7:6] != 2'b10) begin
        st = halt(st, ST_BAD_CONT);
      end else begin
        st.cp   = {st.cp[14:0], b[5:0]};
        st.need = st.need - 2'd1;
        finish  = (st.need == 2'd0);
      end
    end

    // A completed code point: validate, check capacity, then emit.
    if (finish) begin
      if (st.len == 3'd2 && st.cp < 21'h000080) begin
        st = halt(st, ST_OVERLONG);
      end else if (st.len == 3'd3 && (st.cp inside {[21'h00D800:21'h00DFFF]})) begin
        st = halt(st, ST_SURROGATE);
      end else if (st.len == 3'd3 && st.cp < 21'h000800) begin
        st = halt(st, ST_OVERLONG);
      end else if (st.len == 3'd4 && st.cp < 21'h010000) begin
        st = halt(st, ST_OVERLONG);
      end else if (st.cp > 21'h10FFFF) begin
        st = halt(st, ST_RANGE);
      end else begin
        units  = (st.cp <= 21'h00FFFF) ? 2'd1 : 2'd2;
        demand = WW'(produced_i) + WW'(units);
        if (demand > WW'(capacity_i)) begin
          st = halt(st, ST_FULL);
        end else begin
          if (units == 2'd1) begin
            res[0] = make_unit(st.cp[15:0]);
            n      = 2'd1;
          end else begin
            vfull  = st.cp - 21'h010000;
            res[0] = make_unit(16'hD800 | {6'd0, vfull[19:10]});
            res[1] = make_unit(16'hDC00 | {6'd0, vfull[9:0]});
            n      = 2'd2;
          end
          psum = {1'b0, prod} + (COUNT_BITS + 1)'(units);
          prod = psum[COUNT_BITS] ? '1 : psum[COUNT_BITS-1:0];
          csum = {1'b0, cons} + (COUNT_BITS + 1)'(st.len);
          cons = csum[COUNT_BITS] ? '1 : csum[COUNT_BITS-1:0];
        end
      end
    end

    // End of buffer: truncation check, report, then clear the buffer state.
    if (req_i.end_of_buffer) begin
      if (!st.stopped && st.need != 2'd0) begin
        st = halt(st, ST_TRUNCATED);
      end
      cons_w                  = WW'(cons);
      prod_w                  = WW'(prod);
      res[n]                  = '0;
      res[n].item_kind        = KIND_REPORT;
      res[n].status           = st.held;
      res[n].consumed_bytes   = (cons_w > WW'(16'hFFFF)) ? 16'hFFFF : cons_w[15:0];
      res[n].produced_units   = (prod_w > WW'(16'hFFFF)) ? 16'hFFFF : prod_w[15:0];
      n                       = n + 2'd1;
      st                      = '0;
      cons                    = '0;
      prod                    = '0;
    end

    // Mark the final result of this byte.
    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign state_o    = st;
  assign consumed_o = cons;
  assign produced_o = prod;
  assign res_o      = res;
  assign res_num_o  = n;

endmodule

// File: rtl/u8u16_queue.sv
// Result queue: takes up to three items per cycle and hands out one per cycle while it is popped.
`timescale 1ns / 1ps

module u8u16_queue import u8u16_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_num_i,
  input  out_t [MAX_RESULTS-1:0] push_data_i,
  input  logic                   pop_i,
  output out_t                   head_o,
  output logic                   valid_o,
  output logic                   room_o
);

  localparam logic [QPTR_W:0] DEPTH_C = (QPTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W:0] BURST_C = (QPTR_W + 1)'(MAX_RESULTS);

  out_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q + QPTR_W'(push_num_i);
    rptr_d  = rptr_q + QPTR_W'(pop_i);
    count_d = count_q + (QPTR_W + 1)'(push_num_i) - (QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage writes, one slot for each pushed item.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_num_i) begin
        mem_q[wptr_q + QPTR_W'(i)] <= push_data_i[i];
      end
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= DEPTH_C - BURST_C);

  // The fill count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("result queue overfilled");

  // Items are only pushed when the queue had room for a full burst.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num_i != 2'd0) |-> room_o)
    else $error("push without room");

  // A pop with no push lowers the count by one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_num_i == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not lower the count");

endmodule

// File: rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: state, capacity register and queue.
// Results of a taken input byte are written into the registered result queue.
// Throughput: one byte per cycle while results drain; the four-entry result queue
// takes a new byte only when three slots are free, so a byte yielding more than one result
// (a surrogate pair, or a pair and a report) stalls the input until they are free again.
// Reset: decoder state and counters clear, the queue empties, capacity is 65535.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  state_t                 st_q, st_d;
  logic [COUNT_BITS-1:0]  cons_q, cons_d;
  logic [COUNT_BITS-1:0]  prod_q, prod_d;
  logic [15:0]            cap_q;
  out_t [MAX_RESULTS-1:0] res;
  logic [1:0]             res_num;
  logic [1:0]             push_num;
  logic                   room;
  logic                   in_take;
  logic                   out_take;

  assign in_stall_o = !room;
  assign in_take    = in_valid_i && room;
  assign out_take   = out_valid_o && !out_stall_i;
  assign push_num   = in_take ? res_num : 2'd0;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Byte decode.
  u8u16_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .state_i    (st_q),
    .consumed_i (cons_q),
    .produced_i (prod_q),
    .capacity_i (cap_q),
    .req_i      (in_data_i),
    .state_o    (st_d),
    .consumed_o (cons_d),
    .produced_o (prod_d),
    .res_o      (res),
    .res_num_o  (res_num)
  );

  // Decoder state advances on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      cons_q <= '0;
      prod_q <= '0;
    end else if (in_take) begin
      st_q   <= st_d;
      cons_q <= cons_d;
      prod_q <= prod_d;
    end
  end

  // Result queue toward the output channel.
  u8u16_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push_data_i (res),
    .pop_i       (out_take),
    .head_o      (out_data_o),
    .valid_o     (out_valid_o),
    .room_o      (room)
  );

  // The last byte of a buffer always yields at least its report.
  a_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_data_i.end_of_buffer) |-> (res_num != 2'd0))
    else $error("end of buffer gave no report");

  // The final result of a byte carries the last-of-run mark.
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_num != 2'd0) |-> res[res_num - 2'd1].last_of_run)
    else $error("final result not marked");

  // Once stopped, bytes before the end of the buffer yield nothing.
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && st_q.stopped && !in_data_i.end_of_buffer) |-> (res_num == 2'd0))
    else $error("result after stop");

endmodule

// File: tb/sv/utf8_to_utf16_transcoder_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_test;
  import u8u16_pkg::*;

  localparam int unsigned NUM_PHASES = 6;

  // One row of the directed byte table; a typed row carries its single result.
  typedef struct {
    in_t  req;
    bit   typed;
    out_t exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;

  // Row information that travels with the request on the input channel.
  bit          row_typed;
  out_t        row_exp;

  // Code units and reports still owed by the block, oldest first.
  out_t        units_due[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned random_sent;
  int unsigned queued_before;
  dir_row_t    directed[$];

  // Decoder state of the predictor.
  logic [15:0] cap_units    = 16'hFFFF;
  logic [1:0]  dec_need     = '0;
  logic [2:0]  dec_len      = '0;
  logic [20:0] dec_cp       = '0;
  bit          dec_halted   = 1'b0;
  logic [2:0]  dec_held     = ST_OK;
  logic [15:0] dec_consumed = '0;
  logic [15:0] dec_produced = '0;

  // Phase plan: capacity, request count, idle rate and code points per buffer.
  logic [15:0] phase_cap   [NUM_PHASES];
  int unsigned phase_items [NUM_PHASES] = '{16, 60, 90, 30, 110, 90};
  int unsigned phase_idle  [NUM_PHASES] = '{30, 0, 50, 20, 40, 0};
  int unsigned phase_max_cp[NUM_PHASES] = '{2, 3, 8, 2, 10, 8};

  utf8_to_utf16_transcoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mismatch reporting.
  task automatic report_error(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Compare one delivered result with the oldest outstanding expectation.
  task automatic check_result(out_t got);
    out_t want;
    if (units_due.size() == 0) begin
      report_error($sformatf("result %h arrived with nothing expected", got));
    end else begin
      want = units_due.pop_front();
      check_field("item_kind", 16'(got.item_kind), 16'(want.item_kind));
      check_field("code_unit", got.code_unit, want.code_unit);
      check_field("status", 16'(got.status), 16'(want.status));
      check_field("consumed_bytes", got.consumed_bytes, want.consumed_bytes);
      check_field("produced_units", got.produced_units, want.produced_units);
      check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
    end
  endtask

  function automatic logic [15:0] sat_count(logic [15:0] cnt, int unsigned inc);
    logic [16:0] sum;
    sum = {1'b0, cnt} + 17'(inc);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic void stop_decode(logic [2:0] st);
    dec_halted = 1'b1;
    dec_held   = st;
    dec_need   = '0;
  endfunction

  function automatic out_t unit_item(logic [15:0] unit);
    out_t r;
    r             = '0;
    r.item_kind   = KIND_UNIT;
    r.code_unit   = unit;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic out_t report_item(logic [2:0] st, logic [15:0] cons,
                                       logic [15:0] prod);
    out_t r;
    r                = '0;
    r.item_kind      = KIND_REPORT;
    r.status         = st;
    r.consumed_bytes = cons;
    r.produced_units = prod;
    r.last_of_run    = 1'b1;
    return r;
  endfunction

  // Decode one accepted byte and queue the code units and report it causes.
  function automatic void predict_units(in_t req);
    out_t        r;
    logic [20:0] cp;
    logic [19:0] offs;
    int unsigned n_units;
    int unsigned added;
    bit          complete;
    complete = 1'b0;
    added    = 0;
    if (!dec_halted) begin
      if (dec_need == 2'd0) begin
        if (req.in_byte[7] == 1'b0) begin
          dec_cp   = 21'(req.in_byte);
          dec_len  = 3'd1;
          complete = 1'b1;
        end else if (req.in_byte[7:5] == 3'b110) begin
          dec_cp   = 21'(req.in_byte[4:0]);
          dec_len  = 3'd2;
          dec_need = 2'd1;
        end else if (req.in_byte[7:4] == 4'b1110) begin
          dec_cp   = 21'(req.in_byte[3:0]);
          dec_len  = 3'd3;
          dec_need = 2'd2;
        end else if (req.in_byte[7:3] == 5'b11110) begin
          dec_cp   = 21'(req.in_byte[2:0]);
          dec_len  = 3'd4;
          dec_need = 2'd3;
        end else begin
          stop_decode(ST_BAD_LEAD);
        end
      end else if (req.in_byte[7:6] != 2'b10) begin
        stop_decode(ST_BAD_CONT);
      end else begin
        dec_cp   = {dec_cp[14:0], req.in_byte[5:0]};
        dec_need = dec_need - 2'd1;
        complete = (dec_need == 2'd0);
      end
    end

    // Validate a finished code point, then emit it or stop the buffer.
    if (complete) begin
      cp = dec_cp;
      if (dec_len == 3'd2 && cp < 21'h80) begin
        stop_decode(ST_OVERLONG);
      end else if (dec_len == 3'd3 && cp >= 21'hD800 && cp <= 21'hDFFF) begin
        stop_decode(ST_SURROGATE);
      end else if (dec_len == 3'd3 && cp < 21'h800) begin
        stop_decode(ST_OVERLONG);
      end else if (dec_len == 3'd4 && cp < 21'h10000) begin
        stop_decode(ST_OVERLONG);
      end else if (cp > 21'h10FFFF) begin
        stop_decode(ST_RANGE);
      end else begin
        n_units = (cp <= 21'hFFFF) ? 1 : 2;
        if (({1'b0, dec_produced} + 17'(n_units)) > {1'b0, cap_units}) begin
          stop_decode(ST_FULL);
        end else begin
          if (n_units == 1) begin
            units_due.push_back(unit_item(cp[15:0]));
          end else begin
            offs = 20'(cp - 21'h10000);
            units_due.push_back(unit_item(16'hD800 | 16'(offs[19:10])));
            units_due.push_back(unit_item(16'hDC00 | 16'(offs[9:0])));
          end
          added        = n_units;
          dec_produced = sat_count(dec_produced, n_units);
          dec_consumed = sat_count(dec_consumed, int'(dec_len));
        end
      end
    end

    // End of buffer: report, then clear the per-buffer state.
    if (req.end_of_buffer) begin
      if (!dec_halted && dec_need != 2'd0) begin
        stop_decode(ST_TRUNCATED);
      end
      units_due.push_back(report_item(dec_held, dec_consumed, dec_produced));
      added++;
      dec_need     = '0;
      dec_len      = '0;
      dec_cp       = '0;
      dec_halted   = 1'b0;
      dec_held     = ST_OK;
      dec_consumed = '0;
      dec_produced = '0;
    end

    // Only the final item caused by this byte carries the run marker; a
    // single unit item comes from unit_item with the marker already set.
    if (added > 1) begin
      for (int unsigned i = units_due.size() - added; i < units_due.size() - 1; i++) begin
        r                = units_due[i];
        r.last_of_run    = 1'b0;
        units_due[i]     = r;
      end
    end
  endfunction

  // Observe both channels and the register port at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        queued_before = units_due.size();
        predict_units(in_data);
        if (row_typed) begin
          while (units_due.size() > queued_before) begin
            void'(units_due.pop_back());
          end
          units_due.push_back(row_exp);
        end
      end
      if (cfg_we) begin
        cap_units = cfg_wdata;
      end
    end
  end

  // Receiver stalls in short random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(in_t req, bit typed, out_t exp);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    row_typed = typed;
    row_exp   = exp;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [7:0] b, bit eob, bit typed, out_t exp);
    dir_row_t row;
    row.req.in_byte       = b;
    row.req.end_of_buffer = eob;
    row.typed             = typed;
    row.exp               = exp;
    directed.push_back(row);
  endfunction

  function automatic void encode_utf8(ref logic [7:0] seq[$], input logic [20:0] cp,
                                      input int unsigned len);
    case (len)
      1: seq.push_back({1'b0, cp[6:0]});
      2: begin
        seq.push_back({3'b110, cp[10:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq.push_back({4'b1110, cp[15:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq.push_back({5'b11110, cp[20:18]});
        seq.push_back({2'b10, cp[17:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed code points, with some broken or stray sequences mixed in.
  function automatic void append_sequence(ref logic [7:0] seq[$]);
    int unsigned pick;
    int unsigned len;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      len = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      encode_utf8(seq, cp, len);
    end else if (pick < 88) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 91) begin
      // Overlong form of a small code point.
      len = $urandom_range(2, 4);
      cp  = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
      encode_utf8(seq, cp, len);
    end else if (pick < 94) begin
      encode_utf8(seq, 21'($urandom_range('hD800, 'hDFFF)), 3);
    end else if (pick < 97) begin
      encode_utf8(seq, 21'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else begin
      // Multi-byte sequence cut one byte short.
      encode_utf8(seq, 21'($urandom_range('h80, 'h10FFFF)), $urandom_range(2, 4));
      void'(seq.pop_back());
    end
  endfunction

  task automatic send_buffer(int unsigned max_cp);
    logic [7:0] seq[$];
    in_t        req;
    repeat ($urandom_range(1, max_cp)) append_sequence(seq);
    foreach (seq[i]) begin
      req.in_byte       = seq[i];
      req.end_of_buffer = (i == seq.size() - 1);
      send_request(req, 1'b0, '0);
      random_sent++;
    end
  endtask

  // Wait for every owed result, let the block settle, then set the capacity.
  task automatic settle_and_configure(logic [15:0] cap);
    while (units_due.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Main sequence: reset, directed table, then randomized phases.
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    row_typed = 1'b0;
    row_exp   = '0;

    // Extremes of a one-byte unit, the top of the plane, the first pair, the range limit.
    add_row(8'h00, 1'b0, 1'b1, unit_item(16'h0000));
    add_row(8'h7F, 1'b0, 1'b1, unit_item(16'h007F));
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hF0, 1'b0, 1'b0, '0);
    add_row(8'h90, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'hF4, 1'b0, 1'b0, '0);
    add_row(8'h8F, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b0, 1'b0, '0);
    add_row(8'hBF, 1'b1, 1'b0, '0);
    // A 0xC0 lead is taken, and the finished value is overlong.
    add_row(8'hC0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b1, report_item(ST_OVERLONG, 16'd0, 16'd0));
    // A 0xF5 lead is taken, and the finished value is above range.
    add_row(8'hF5, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b1, report_item(ST_RANGE, 16'd0, 16'd0));
    // Encoded surrogate half.
    add_row(8'hED, 1'b0, 1'b0, '0);
    add_row(8'hA0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b1, report_item(ST_SURROGATE, 16'd0, 16'd0));
    // Bad lead, bad continuation, and a sequence open at the end.
    add_row(8'hFF, 1'b1, 1'b1, report_item(ST_BAD_LEAD, 16'd0, 16'd0));
    add_row(8'hE2, 1'b0, 1'b0, '0);
    add_row(8'h41, 1'b1, 1'b1, report_item(ST_BAD_CONT, 16'd0, 16'd0));
    add_row(8'hE2, 1'b1, 1'b1, report_item(ST_TRUNCATED, 16'd0, 16'd0));

    phase_cap[0] = 16'd0;
    phase_cap[1] = 16'd2;
    phase_cap[2] = 16'($urandom_range(3, 24));
    phase_cap[3] = 16'd1;
    phase_cap[4] = 16'hFFFF;
    phase_cap[5] = 16'($urandom_range(0, 'hFFFF));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    idle_pct = 25;
    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].typed, directed[i].exp);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      settle_and_configure(phase_cap[p]);
      idle_pct    = phase_idle[p];
      random_sent = 0;
      while (random_sent < phase_items[p]) send_buffer(phase_max_cp[p]);
    end

    in_valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
